FILE: design/mbp_pkg.sv
// Package: constants, state type and control structs for the MSB-first bit packer.
`default_nettype none
package mbp_pkg;
    localparam int CODE_W        = 32;
    localparam int LEN_W         = 6;
    localparam int MAX_CODE_BITS = 32;
    localparam int COUNT_W       = 48;
    localparam int TOTAL_W       = 48;
    localparam int BYTE_W        = 8;
    localparam int PEND_W        = BYTE_W - 1;
    localparam int PCNT_W        = 3;
    localparam int ACC_W         = CODE_W + PEND_W;
    localparam int ACC_N_W       = 6;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam int LEN_LIMIT     = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;

    localparam logic KIND_PUSH  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic REG_REPORT_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_FLUSH
    } t_mbp_state;

    typedef struct packed {
        logic in_ready;
        logic take_push;
        logic emit_byte;
        logic emit_flush;
    } t_mbp_cmd;

    typedef struct packed {
        logic push_full;
        logic emit_final;
        logic slot_free;
    } t_mbp_sts;
endpackage
`default_nettype wire

FILE: design/mbp_if.sv
// Request and result channel interfaces of the bit packer.
`default_nettype none
interface mbp_in_if;
    import mbp_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [CODE_W-1:0] code_value;
    logic [LEN_W-1:0]  code_length;

    modport source (output valid, kind, code_value, code_length, input ready);
    modport sink   (input valid, kind, code_value, code_length, output ready);
endinterface

interface mbp_out_if;
    import mbp_pkg::*;
    logic               valid;
    logic               ready;
    logic               byte_valid;
    logic [BYTE_W-1:0]  out_byte;
    logic               last;
    logic               length_valid;
    logic [TOTAL_W-1:0] total_bits;

    modport source (output valid, byte_valid, out_byte, last, length_valid, total_bits,
                    input ready);
    modport sink   (input valid, byte_valid, out_byte, last, length_valid, total_bits,
                    output ready);
endinterface
`default_nettype wire

FILE: design/mbp_ctrl.sv
// Controller state machine: request intake, byte emission and flush sequencing.
`default_nettype none
module mbp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    input  mbp_pkg::t_mbp_sts i_sts,
    output mbp_pkg::t_mbp_cmd o_cmd
);
    import mbp_pkg::*;

    t_mbp_state r_state;
    t_mbp_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_kind == KIND_FLUSH) begin
                        n_state = S_FLUSH;
                    end else if (i_sts.push_full) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_sts.slot_free && i_sts.emit_final) begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_sts.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready  = 1'b1;
                o_cmd.take_push = i_in_valid && (i_in_kind == KIND_PUSH);
            end
            S_EMIT: begin
                o_cmd.emit_byte = i_sts.slot_free;
            end
            S_FLUSH: begin
                o_cmd.emit_flush = i_sts.slot_free;
            end
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

FILE: design/mbp_dp.sv
// Datapath: bit accumulator, pending bits, payload counter and result register.
`default_nettype none
module mbp_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mbp_pkg::t_mbp_cmd           i_cmd,
    output mbp_pkg::t_mbp_sts           o_sts,
    input  logic [mbp_pkg::CODE_W-1:0]  i_code_value,
    input  logic [mbp_pkg::LEN_W-1:0]   i_code_length,
    input  logic                        i_report_length,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_byte_valid,
    output logic [mbp_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_last,
    output logic                        o_length_valid,
    output logic [mbp_pkg::TOTAL_W-1:0] o_total_bits
);
    import mbp_pkg::*;

    logic [PEND_W-1:0]  r_pend;
    logic [PCNT_W-1:0]  r_pcnt;
    logic [ACC_W-1:0]   r_acc;
    logic [ACC_N_W-1:0] r_n;
    logic [COUNT_W-1:0] r_count;

    logic               r_out_valid;
    logic               r_byte_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_last;
    logic               r_length_valid;
    logic [TOTAL_W-1:0] r_total_bits;

    logic [LEN_W-1:0]   len;
    logic [CODE_W-1:0]  value_m;
    logic [ACC_W-1:0]   acc_new;
    logic [ACC_N_W-1:0] n_total;
    logic [COUNT_W:0]   count_sum;
    logic [COUNT_W-1:0] count_new;
    logic [ACC_N_W-1:0] n_rem;
    logic [ACC_W-1:0]   acc_sh;
    logic [PEND_W-1:0]  pend_mask;
    logic [BYTE_W-1:0]  flush_byte;
    logic [BYTE_W-1:0]  flush_sh;

    always_comb begin
        len = (i_code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : i_code_length;
        value_m = i_code_value & ~({CODE_W{1'b1}} << len);
        acc_new = (ACC_W'(r_pend) << len) | ACC_W'(value_m);
        n_total = ACC_N_W'(r_pcnt) + len;
        count_sum = {1'b0, r_count} + (COUNT_W + 1)'(len);
        count_new = count_sum[COUNT_W] ? {COUNT_W{1'b1}} : count_sum[COUNT_W-1:0];

        n_rem = r_n - ACC_N_W'(BYTE_W);
        acc_sh = r_acc >> n_rem;
        pend_mask = ~({PEND_W{1'b1}} << n_rem[PCNT_W-1:0]);

        flush_sh = {1'b0, r_pend} << (PCNT_W'(0) - r_pcnt);
        flush_byte = (r_pcnt == '0) ? '0 : flush_sh;
    end

    assign o_sts.push_full  = n_total >= ACC_N_W'(BYTE_W);
    assign o_sts.emit_final = n_rem < ACC_N_W'(BYTE_W);
    assign o_sts.slot_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_pcnt      <= '0;
            r_n         <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take_push) begin
                r_count <= count_new;
                if (n_total < ACC_N_W'(BYTE_W)) begin
                    r_pend <= acc_new[PEND_W-1:0];
                    r_pcnt <= n_total[PCNT_W-1:0];
                end else begin
                    r_n <= n_total;
                end
            end
            if (i_cmd.emit_byte) begin
                r_n <= n_rem;
                if (n_rem < ACC_N_W'(BYTE_W)) begin
                    r_pend <= r_acc[PEND_W-1:0] & pend_mask;
                    r_pcnt <= n_rem[PCNT_W-1:0];
                end
            end
            if (i_cmd.emit_flush) begin
                r_pend  <= '0;
                r_pcnt  <= '0;
                r_count <= '0;
            end
            if (i_cmd.emit_byte || i_cmd.emit_flush) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_push) begin
            r_acc <= acc_new;
        end
        if (i_cmd.emit_byte) begin
            r_byte_valid   <= 1'b1;
            r_out_byte     <= acc_sh[BYTE_W-1:0];
            r_last         <= n_rem < ACC_N_W'(BYTE_W);
            r_length_valid <= 1'b0;
            r_total_bits   <= '0;
        end else if (i_cmd.emit_flush) begin
            r_byte_valid   <= r_pcnt != '0;
            r_out_byte     <= flush_byte;
            r_last         <= 1'b1;
            r_length_valid <= i_report_length;
            r_total_bits   <= i_report_length ? r_count[TOTAL_W-1:0] : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_valid   = r_byte_valid;
    assign o_out_byte     = r_out_byte;
    assign o_last         = r_last;
    assign o_length_valid = r_length_valid;
    assign o_total_bits   = r_total_bits;
endmodule
`default_nettype wire

FILE: design/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer: APB register, controller and datapath.
//
//  channel   direction  handshake        payload
//  i_in_ch   in         valid / ready    kind, code_value, code_length
//  o_out_ch  out        valid / ready    byte_valid, out_byte, last, length_valid, total_bits
//  APB       in         psel / penable   report_length at offset 0
//
// A push that completes k bytes (1 to 4) is taken in S_IDLE, then S_EMIT sends one byte
// per cycle through the single result register whenever that register is free.
// A push that completes no byte leaves S_IDLE ready for the next request; a flush passes S_FLUSH.
// A stalled result register holds the byte sequencer until it drains.
// Synchronous active-low reset clears the pending bits, the count and
// sets report_length to 1.
`default_nettype none
module msb_first_bit_packer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mbp_in_if.sink                     i_in_ch,
    mbp_out_if.source                  o_out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mbp_pkg::ADDR_W-1:0] paddr,
    input  logic [mbp_pkg::DATA_W-1:0] pwdata,
    output logic [mbp_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import mbp_pkg::*;

    logic     r_report_length;
    t_mbp_cmd cmd;
    t_mbp_sts sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_length <= 1'b1;
        end else if (psel && penable && pwrite && paddr[2] == REG_REPORT_LENGTH) begin
            r_report_length <= pwdata[0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_REPORT_LENGTH: prdata = {{(DATA_W-1){1'b0}}, r_report_length};
            default:           prdata = '0;
        endcase
    end

    mbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_in_kind  (i_in_ch.kind),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    assign i_in_ch.ready = cmd.in_ready;

    mbp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_code_value    (i_in_ch.code_value),
        .i_code_length   (i_in_ch.code_length),
        .i_report_length (r_report_length),
        .i_out_ready     (o_out_ch.ready),
        .o_out_valid     (o_out_ch.valid),
        .o_byte_valid    (o_out_ch.byte_valid),
        .o_out_byte      (o_out_ch.out_byte),
        .o_last          (o_out_ch.last),
        .o_length_valid  (o_out_ch.length_valid),
        .o_total_bits    (o_out_ch.total_bits)
    );
endmodule
`default_nettype wire

FILE: design/mbp_checker.sv
// Port-level checker for the bit packer and its bind to the top level.
`default_nettype none
module mbp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_byte_valid,
    input logic [mbp_pkg::BYTE_W-1:0]  i_out_byte,
    input logic                        i_last,
    input logic                        i_length_valid,
    input logic [mbp_pkg::TOTAL_W-1:0] i_total_bits
);
    import mbp_pkg::*;

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped while stalled");

    a_length_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_length_valid |-> i_last)
        else $error("length reported on a result that is not last");

    a_total_only_with_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_length_valid |-> i_total_bits == '0)
        else $error("total_bits nonzero without length_valid");

    a_empty_flush_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> (i_out_byte == '0) && i_last)
        else $error("empty flush result malformed");
endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out_ch.valid),
    .i_out_ready    (o_out_ch.ready),
    .i_byte_valid   (o_out_ch.byte_valid),
    .i_out_byte     (o_out_ch.out_byte),
    .i_last         (o_out_ch.last),
    .i_length_valid (o_out_ch.length_valid),
    .i_total_bits   (o_out_ch.total_bits)
);
`default_nettype wire
